>>> rtl/hmvg_pkg.sv
// shared types and constants of the heightfield mesh vertex generator
package hmvg_pkg;

  // field and port widths
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 256;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int GRID_W     = 14;
  localparam int TILE_W     = 24;
  localparam int ROW_W      = 13;
  localparam int MAX_ROWS   = 8192;
  localparam int IDX_W      = 26;
  localparam int POS_W      = 38;
  localparam int HGT_W      = 32;
  localparam int TEX_W      = 35;
  localparam int NRM_W      = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE   = 2'd2;

  // iteration counts of the shared units
  localparam int MUL_OPS     = 8;
  localparam int MUL_CYCLES  = 9;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 15;
  localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } hmvg_state_t;

  typedef enum logic [2:0] {
    MS_SQ_X,
    MS_SQ_Y,
    MS_SQ_Z,
    MS_POS_X,
    MS_POS_Z,
    MS_TEX_U,
    MS_TEX_V,
    MS_INDEX
  } hmvg_mul_op_t;

  typedef struct packed {
    logic accept;
    logic build;
    logic load;
    logic mul;
    logic sqrt;
    logic div_init;
    logic div;
    logic emit;
  } hmvg_cmd_t;

  typedef struct packed {
    logic none;
    logic more;
    logic mul_last;
    logic sqrt_last;
    logic div_last;
    logic out_free;
  } hmvg_status_t;

endpackage

>>> rtl/heightfield_mesh_vertex_generator.sv
// top level of the heightfield mesh vertex generator
//
// Height samples arrive in raster order; each vertex is sent once the sample below it
// arrives, and the last row sends up to two more per sample. Each vertex an item causes
// (0 to 3) takes a pass of the shared multiplier, a 32-step square root, 15 steps of
// the three dividers and setup and emit cycles; the next sample is taken only after the
// last of them is emitted. The row stores are plain memories with no clearing pass;
// writing any register restarts the frame.
module heightfield_mesh_vertex_generator #(
  parameter int MAX_WIDTH = 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hmvg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hmvg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hmvg_pkg::S_TDATA_W-1:0]  s_tdata,   // height_sample[31:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // vertex_index[25:0], pos_x[63:26], pos_y[95:64], pos_z[133:96], tex_u[168:134],
  // tex_v[203:169], normal_x[219:204], normal_y[235:220], normal_z[251:236], zero pad
  output logic [hmvg_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tlast    // last_vertex
);
  import hmvg_pkg::*;

  hmvg_cmd_t    cmd;
  hmvg_status_t st;

  // sequencer
  hmvg_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and arithmetic
  hmvg_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> rtl/hmvg_controller.sv
// sequencing state machine of the vertex generator
module hmvg_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  hmvg_pkg::hmvg_status_t st,
  output hmvg_pkg::hmvg_cmd_t    cmd
);
  import hmvg_pkg::*;

  hmvg_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.build  = 1'b1;
        state_next = st.none ? ST_IDLE : ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (st.mul_last) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt = 1'b1;
        if (st.sqrt_last) state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = st.more ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/hmvg_datapath.sv
// row stores, vertex setup, shared multiplier, square root, dividers and output register
module hmvg_datapath #(
  parameter int MAX_WIDTH = 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  input  hmvg_pkg::hmvg_cmd_t             cmd,
  output hmvg_pkg::hmvg_status_t          st,
  input  logic                            cfg_we,
  input  logic [hmvg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hmvg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [hmvg_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [hmvg_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import hmvg_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [GRID_W-1:0] gw, gh;
  logic [TILE_W-1:0] ts;
  logic              cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == CFG_GRID_WIDTH || cfg_index == CFG_GRID_HEIGHT ||
                              cfg_index == CFG_TILE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gw <= 14'd2;
      gh <= 14'd2;
      ts <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  gw <= cfg_data[GRID_W-1:0];
        CFG_GRID_HEIGHT: gh <= cfg_data[GRID_W-1:0];
        CFG_TILE_SIZE:   ts <= cfg_data[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes and tile
  logic [31:0]       w32, h32;
  logic [TILE_W-1:0] t_eff;

  always_comb begin
    w32 = 32'(gw);
    if (w32 < 32'd2) w32 = 32'd2;
    if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    h32 = 32'(gh);
    if (h32 < 32'd2) h32 = 32'd2;
    if (h32 > 32'(MAX_ROWS)) h32 = 32'(MAX_ROWS);
    t_eff = (ts == '0) ? 24'd65536 : ts;
  end

  // raster position and accepted item
  logic [XW-1:0]           col, cur_c, c_in;
  logic [ROW_W-1:0]        row, cur_r, r_in;
  logic signed [HGT_W-1:0] cur_s;
  logic                    wrap;

  assign wrap = (32'(col) >= w32) || (32'(row) >= h32);
  assign c_in = wrap ? '0 : col;
  assign r_in = wrap ? '0 : row;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_c <= c_in;
      cur_r <= r_in;
      cur_s <= signed'(s_tdata[HGT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (cmd.build) begin
      if (32'(cur_c) + 32'd1 >= w32) begin
        col <= '0;
        if (32'(cur_r) + 32'd1 >= h32) row <= '0;
        else row <= cur_r + 1'b1;
      end else begin
        col <= cur_c + 1'b1;
      end
    end
  end

  // row stores
  logic signed [HGT_W-1:0] middle_mem [MAX_WIDTH];
  logic signed [HGT_W-1:0] upper_mem  [MAX_WIDTH];
  logic signed [HGT_W-1:0] mid_q, right_q, up_q;
  logic [XW-1:0]           c_next_addr;

  assign c_next_addr = c_in + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mid_q   <= middle_mem[c_in];
      right_q <= middle_mem[c_next_addr];
      up_q    <= upper_mem[c_in];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build) begin
      middle_mem[cur_c] <= cur_s;
      if (cur_r != '0) upper_mem[cur_c] <= mid_q;
    end
  end

  // recent samples of the current row and of the row above
  logic signed [HGT_W-1:0] rec0, s1, s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec0 <= '0;
      s1   <= '0;
      s2   <= '0;
    end else if (cmd.build) begin
      if (cur_r != '0) rec0 <= mid_q;
      s1 <= cur_s;
      s2 <= s1;
    end
  end

  // vertices caused by the item
  logic                    last_row, at_right, has_v1, has_v2;
  logic [1:0]              nvert, vcount, k;
  logic signed [HGT_W-1:0] left0, right0, up0;

  always_comb begin
    last_row = 32'(cur_r) == h32 - 32'd1;
    at_right = 32'(cur_c) + 32'd1 >= w32;
    has_v1   = last_row && (cur_c != '0);
    has_v2   = last_row && at_right;
    nvert    = (cur_r == '0) ? 2'd0 : 2'd1 + {1'b0, has_v1} + {1'b0, has_v2};
    left0    = (cur_c == '0) ? mid_q : rec0;
    right0   = at_right ? mid_q : right_q;
    up0      = (cur_r == ROW_W'(1)) ? mid_q : up_q;
  end

  logic [XW-1:0]           ent_x    [3];
  logic [ROW_W-1:0]        ent_y    [3];
  logic signed [HGT_W-1:0] ent_hc   [3];
  logic signed [HGT_W-1:0] ent_hl   [3];
  logic signed [HGT_W-1:0] ent_hr   [3];
  logic signed [HGT_W-1:0] ent_hd   [3];
  logic signed [HGT_W-1:0] ent_hu   [3];
  logic                    ent_last [3];

  always_ff @(posedge clk) begin
    if (cmd.build) begin
      ent_x[0] <= cur_c;          ent_y[0] <= cur_r - 1'b1;
      ent_hc[0] <= mid_q;         ent_hl[0] <= left0;  ent_hr[0] <= right0;
      ent_hd[0] <= up0;           ent_hu[0] <= cur_s;  ent_last[0] <= 1'b0;
      ent_x[1] <= cur_c - 1'b1;   ent_y[1] <= cur_r;
      ent_hc[1] <= s1;            ent_hl[1] <= (cur_c == XW'(1)) ? s1 : s2;
      ent_hr[1] <= cur_s;         ent_hd[1] <= rec0;   ent_hu[1] <= s1;
      ent_last[1] <= 1'b0;
      ent_x[2] <= cur_c;          ent_y[2] <= cur_r;
      ent_hc[2] <= cur_s;         ent_hl[2] <= s1;     ent_hr[2] <= cur_s;
      ent_hd[2] <= mid_q;         ent_hu[2] <= cur_s;  ent_last[2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      vcount <= '0;
    end else if (cmd.build) begin
      k      <= '0;
      vcount <= nvert;
    end else if (cmd.emit) begin
      k <= k + 1'b1;
    end
  end

  // vertex setup: differences, magnitudes and common scaling
  logic signed [32:0]      dx, dz;
  logic [31:0]             ax, ay, az, am;
  logic [1:0]              sh;
  logic [XW-1:0]           wx;
  logic [ROW_W-1:0]        wy;
  logic signed [HGT_W-1:0] whc;
  logic                    wlast, neg_x, neg_z;
  logic [29:0]             a_s [3];

  always_comb begin
    dx = {ent_hl[k][31], ent_hl[k]} - {ent_hr[k][31], ent_hr[k]};
    dz = {ent_hd[k][31], ent_hd[k]} - {ent_hu[k][31], ent_hu[k]};
    ax = dx[32] ? 32'(-dx) : dx[31:0];
    az = dz[32] ? 32'(-dz) : dz[31:0];
    ay = 32'({t_eff, 1'b0});
    am = ax;
    if (ay > am) am = ay;
    if (az > am) am = az;
    if (am[31]) sh = 2'd2;
    else if (am[30]) sh = 2'd1;
    else sh = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wx     <= ent_x[k];
      wy     <= ent_y[k];
      whc    <= ent_hc[k];
      wlast  <= ent_last[k];
      neg_x  <= dx[32];
      neg_z  <= dz[32];
      a_s[0] <= 30'(ax >> sh);
      a_s[1] <= 30'(ay >> sh);
      a_s[2] <= 30'(az >> sh);
    end
  end

  // shared multiplier, product registered before use
  logic [3:0]              mcnt;
  hmvg_mul_op_t            mop, mop_q;
  logic signed [31:0]      opa, opb;
  logic signed [63:0]      prod_q;
  logic [63:0]             acc;
  logic [POS_W-1:0]        posx, posz;
  logic [TEX_W-1:0]        texu, texv;
  logic [IDX_W-1:0]        vidx;

  assign mop = hmvg_mul_op_t'(mcnt[2:0]);

  always_comb begin
    opa = '0;
    opb = '0;
    case (mop)
      MS_SQ_X:  begin opa = signed'(32'(a_s[0])); opb = opa; end
      MS_SQ_Y:  begin opa = signed'(32'(a_s[1])); opb = opa; end
      MS_SQ_Z:  begin opa = signed'(32'(a_s[2])); opb = opa; end
      MS_POS_X: begin
        opa = signed'((32'(wx) << 1) - (w32 - 32'd1));
        opb = signed'(32'(t_eff));
      end
      MS_POS_Z: begin
        opa = signed'((32'(wy) << 1) - (h32 - 32'd1));
        opb = signed'(32'(t_eff));
      end
      MS_TEX_U: begin opa = signed'(32'(wx)); opb = signed'(32'(t_eff)); end
      MS_TEX_V: begin opa = signed'(32'(wy)); opb = signed'(32'(t_eff)); end
      MS_INDEX: begin opa = signed'(32'(wy)); opb = signed'(w32); end
      default: ;
    endcase
  end

  // square root registers
  logic [63:0] res, bitm, rb;
  logic [4:0]  scnt;

  assign rb = res + bitm;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mcnt <= '0;
      acc  <= '0;
      res  <= '0;
      bitm <= 64'd1 << 62;
      scnt <= '0;
    end else if (cmd.mul) begin
      mcnt <= mcnt + 1'b1;
      if (mcnt < 4'(MUL_OPS)) begin
        prod_q <= opa * opb;
        mop_q  <= mop;
      end
      if (mcnt != '0) begin
        case (mop_q)
          MS_SQ_X, MS_SQ_Y, MS_SQ_Z: acc <= acc + unsigned'(prod_q);
          MS_POS_X: posx <= prod_q[POS_W:1];
          MS_POS_Z: posz <= prod_q[POS_W:1];
          MS_TEX_U: texu <= prod_q[TEX_W+2:3];
          MS_TEX_V: texv <= prod_q[TEX_W+2:3];
          MS_INDEX: vidx <= IDX_W'(prod_q[31:0] + 32'(wx));
          default: ;
        endcase
      end
    end else if (cmd.sqrt) begin
      // one result bit per step
      scnt <= scnt + 1'b1;
      if (acc >= rb) begin
        acc <= acc - rb;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  // three restoring dividers, one quotient bit a step
  logic [31:0]       len;
  logic [31:0]       rem  [3];
  logic [14:0]       nlow [3];
  logic [14:0]       q    [3];
  logic [44:0]       num  [3];
  logic [32:0]       trial [3];
  logic [3:0]        dcnt;

  assign len = res[31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]   = {1'b0, a_s[i], 14'b0} + 45'(len >> 1);
      trial[i] = {rem[i], nlow[i][14]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dcnt <= '0;
      for (int i = 0; i < 3; i++) begin
        rem[i]  <= 32'(num[i][44:15]);
        nlow[i] <= num[i][14:0];
        q[i]    <= '0;
      end
    end else if (cmd.div) begin
      dcnt <= dcnt + 1'b1;
      for (int i = 0; i < 3; i++) begin
        nlow[i] <= nlow[i] << 1;
        if (trial[i] >= {1'b0, len}) begin
          rem[i] <= 32'(trial[i] - {1'b0, len});
          q[i]   <= {q[i][13:0], 1'b1};
        end else begin
          rem[i] <= trial[i][31:0];
          q[i]   <= {q[i][13:0], 1'b0};
        end
      end
    end
  end

  // signed normal, degenerate length gives straight up
  logic signed [NRM_W-1:0] nx, ny, nz;

  always_comb begin
    if (len == '0) begin
      nx = '0;
      ny = NRM_ONE;
      nz = '0;
    end else begin
      nx = neg_x ? -signed'(16'(q[0])) : signed'(16'(q[0]));
      ny = signed'(16'(q[1]));
      nz = neg_z ? -signed'(16'(q[2])) : signed'(16'(q[2]));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0, nz, ny, nx, texv, texu, posz, whc, posx, vidx};
      m_tlast <= wlast;
    end
  end

  // status
  always_comb begin
    st.none      = nvert == 2'd0;
    st.more      = (3'(k) + 3'd1) < 3'(vcount);
    st.mul_last  = mcnt == 4'(MUL_CYCLES - 1);
    st.sqrt_last = scnt == 5'(SQRT_STEPS - 1);
    st.div_last  = dcnt == 4'(DIV_STEPS - 1);
    st.out_free  = !m_tvalid || m_tready;
  end

endmodule

>>> tb/heightfield_mesh_vertex_generator_tb.sv
// self-checking testbench of the heightfield mesh vertex generator
module heightfield_mesh_vertex_generator_tb;
  import hmvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_CAP = 8192;
  localparam int QUIET_CYCLES = 250;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;

  typedef struct {
    logic [IDX_W-1:0] vidx;
    logic [POS_W-1:0] px;
    logic [HGT_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
    logic [NRM_W-1:0] nx;
    logic [NRM_W-1:0] ny;
    logic [NRM_W-1:0] nz;
    logic             lastv;
  } vertex_t;

  vertex_t vertex_q[$];

  // mirror of the block state
  int            mdl_width, mdl_height, mdl_tile;
  int            upper_row[ROW_CAP];
  int            middle_row[ROW_CAP];
  int            col_cnt, row_cnt;
  int            prev_mid;

  int errors;
  int vertices_seen;
  int items_sent;
  int frames_done;
  int idle_pct;
  int stall_pct;

  heightfield_mesh_vertex_generator DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #60ms;
    $display("[heightfield_mesh_vertex_generator] ERROR");
    $finish;
  end

  function automatic int eff_w();
    if (mdl_width < 2) return 2;
    if (mdl_width > ROW_CAP) return ROW_CAP;
    return mdl_width;
  endfunction

  function automatic int eff_h();
    if (mdl_height < 2) return 2;
    if (mdl_height > MAX_ROWS) return MAX_ROWS;
    return mdl_height;
  endfunction

  function automatic longint eff_t();
    return (mdl_tile == 0) ? 64'sd65536 : longint'(mdl_tile);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // build one expected vertex with its unit normal
  function automatic vertex_t make_vertex(int x, int y, longint hc, longint hl, longint hr,
                                          longint hd, longint hu, bit lastv);
    vertex_t         v;
    longint          d[3];
    longint unsigned a[3];
    longint unsigned m, len, q;
    longint          t, n;
    int              sh;
    t = eff_t();
    d[0] = hl - hr;
    d[1] = 2 * t;
    d[2] = hd - hu;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      if (a[i] > m) m = a[i];
    end
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) a[i] = a[i] >> sh;
    len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    v.vidx = IDX_W'(longint'(y) * eff_w() + x);
    v.px = POS_W'((longint'(2 * x) - longint'(eff_w() - 1)) * t >>> 1);
    v.py = HGT_W'(hc);
    v.pz = POS_W'((longint'(2 * y) - longint'(eff_h() - 1)) * t >>> 1);
    v.tu = TEX_W'((longint'(x) * t) >> 3);
    v.tv = TEX_W'((longint'(y) * t) >> 3);
    if (len == 0) begin
      v.nx = '0;
      v.ny = NRM_ONE;
      v.nz = '0;
    end else begin
      q = (a[0] * 16384 + len / 2) / len;
      n = (d[0] < 0) ? -longint'(q) : longint'(q);
      v.nx = NRM_W'(n);
      q = (a[1] * 16384 + len / 2) / len;
      n = (d[1] < 0) ? -longint'(q) : longint'(q);
      v.ny = NRM_W'(n);
      q = (a[2] * 16384 + len / 2) / len;
      n = (d[2] < 0) ? -longint'(q) : longint'(q);
      v.nz = NRM_W'(n);
    end
    v.lastv = lastv;
    return v;
  endfunction

  // advance the mirror by one height item and queue the vertices it releases
  task automatic predict_vertices(logic [31:0] raw);
    int     w, h, c, r;
    longint s, mid, lf, rt, up, ctr, l2;
    w = eff_w();
    h = eff_h();
    c = col_cnt;
    r = row_cnt;
    s = longint'(signed'(raw));
    if (c >= w || r >= h) begin
      c = 0;
      r = 0;
    end
    if (r == 0) begin
      middle_row[c] = int'(s);
    end else begin
      mid = middle_row[c];
      lf = (c == 0) ? mid : longint'(prev_mid);
      rt = (c + 1 >= w) ? mid : longint'(middle_row[c + 1]);
      up = (r == 1) ? mid : longint'(upper_row[c]);
      vertex_q.push_back(make_vertex(c, r - 1, mid, lf, rt, up, s, 1'b0));
      prev_mid = int'(mid);
      upper_row[c] = int'(mid);
      middle_row[c] = int'(s);
      if (r == h - 1) begin
        if (c >= 1) begin
          ctr = middle_row[c - 1];
          l2 = (c == 1) ? ctr : longint'(middle_row[c - 2]);
          vertex_q.push_back(make_vertex(c - 1, r, ctr, l2, s, upper_row[c - 1], ctr, 1'b0));
        end
        if (c == w - 1) begin
          vertex_q.push_back(make_vertex(c, r, s, middle_row[c - 1], s, upper_row[c], s,
                                         1'b1));
          frames_done++;
        end
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  // send one height item, idling first at the current rate
  task automatic send_height(logic [31:0] hgt);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = hgt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertices(hgt);
    items_sent++;
    @(negedge clk);
  endtask

  // let every expected vertex drain, then give the block time to settle
  task automatic wait_quiet();
    s_tvalid = 1'b0;
    while (vertex_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_quiet();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_GRID_WIDTH: begin
        mdl_width = int'(val[GRID_W-1:0]);
        col_cnt = 0;
        row_cnt = 0;
      end
      CFG_GRID_HEIGHT: begin
        mdl_height = int'(val[GRID_W-1:0]);
        col_cnt = 0;
        row_cnt = 0;
      end
      CFG_TILE_SIZE: begin
        mdl_tile = int'(val);
        col_cnt = 0;
        row_cnt = 0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_grid(int w, int h, logic [CFG_DATA_W-1:0] tile);
    write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_TILE_SIZE, tile);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on vertex %0d field %s: got %h expected %h",
             vertices_seen, field, got, want);
    errors++;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= stall_pct);
  end

  // check each vertex against the oldest expectation
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        $display("unexpected vertex, index %h", m_tdata[25:0]);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (m_tdata[25:0] !== e.vidx) report_mismatch("vertex_index", m_tdata[25:0], e.vidx);
        if (m_tdata[63:26] !== e.px) report_mismatch("pos_x", m_tdata[63:26], e.px);
        if (m_tdata[95:64] !== e.py) report_mismatch("pos_y", m_tdata[95:64], e.py);
        if (m_tdata[133:96] !== e.pz) report_mismatch("pos_z", m_tdata[133:96], e.pz);
        if (m_tdata[168:134] !== e.tu) report_mismatch("tex_u", m_tdata[168:134], e.tu);
        if (m_tdata[203:169] !== e.tv) report_mismatch("tex_v", m_tdata[203:169], e.tv);
        if (m_tdata[219:204] !== e.nx) report_mismatch("normal_x", m_tdata[219:204], e.nx);
        if (m_tdata[235:220] !== e.ny) report_mismatch("normal_y", m_tdata[235:220], e.ny);
        if (m_tdata[251:236] !== e.nz) report_mismatch("normal_z", m_tdata[251:236], e.nz);
        if (m_tdata[255:252] !== 4'd0) report_mismatch("pad", m_tdata[255:252], 0);
        if (m_tlast !== e.lastv) report_mismatch("last_vertex", m_tlast, e.lastv);
      end
      vertices_seen++;
    end
  end

  // default 2x2 grid straight out of reset, with height extremes
  task automatic test_reset_frame();
    send_height(32'h7fff_ffff);
    send_height(32'h8000_0000);
    send_height(32'h0000_0000);
    send_height(32'hffff_ffff);
  endtask

  // tile extremes and the zero tile, on a 3x3 grid with steep slopes
  task automatic test_tile_extremes();
    logic [CFG_DATA_W-1:0] tiles[3];
    tiles[0] = '0;
    tiles[1] = 24'hff_ffff;
    tiles[2] = 24'h00_0001;
    foreach (tiles[k]) begin
      set_grid(3, 3, tiles[k]);
      for (int i = 0; i < 9; i++)
        send_height((i % 2 == 0) ? 32'h7fff_ffff : 32'h8000_0000);
    end
  endtask

  // widths and heights below two are clamped, upper data bits dropped
  task automatic test_size_clamps();
    set_grid(0, 1, 24'h01_0000);
    for (int i = 0; i < 4; i++) send_height($urandom);
    write_reg(CFG_GRID_WIDTH, {10'h3ff, 14'd1});
    write_reg(CFG_GRID_HEIGHT, {10'h2aa, 14'd3});
    for (int i = 0; i < 6; i++) send_height($urandom);
  endtask

  // widest rows: a few row-zero items release no vertex before the frame restarts
  task automatic test_wide_rows(int w);
    set_grid(w, 2, 24'h00_8000);
    for (int i = 0; i < 6; i++) send_height($urandom);
  endtask

  // tallest grid: only the first rows are run
  task automatic test_tall_grid();
    set_grid(2, 8192, 24'h02_0000);
    for (int i = 0; i < 8; i++) send_height($urandom);
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(16383));
    for (int i = 0; i < 6; i++) send_height($urandom);
  endtask

  // a write to the unused index leaves the frame running
  task automatic test_ignored_index();
    set_grid(3, 2, 24'h01_8000);
    for (int i = 0; i < 3; i++) send_height($urandom);
    write_reg(CFG_IDX_W'(3), 24'h00_0005);
    for (int i = 0; i < 3; i++) send_height($urandom);
  endtask

  // random frames, mostly complete, some cut short by a register write
  task automatic test_random_frames(int idle, int stall, int item_goal);
    int start, w, h, n;
    logic [31:0] hgt;
    idle_pct = idle;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(2, 6);
      h = $urandom_range(2, 5);
      set_grid(w, h, ($urandom_range(3) == 0) ? 24'(1 << $urandom_range(23)) : 24'($urandom));
      n = w * h;
      if ($urandom_range(9) == 0) n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0: hgt = $urandom;
          1: hgt = 32'($urandom_range(65536 * 8)) - 32'd262144;
          2: hgt = ($urandom_range(1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
          default: hgt = 32'h0001_0000 * $urandom_range(4);
        endcase
        send_height(hgt);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    errors = 0;
    vertices_seen = 0;
    items_sent = 0;
    frames_done = 0;
    idle_pct = 0;
    stall_pct = 0;
    mdl_width = 2;
    mdl_height = 2;
    mdl_tile = 65536;
    col_cnt = 0;
    row_cnt = 0;
    prev_mid = 0;
    foreach (upper_row[i]) upper_row[i] = 0;
    foreach (middle_row[i]) middle_row[i] = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_reset_frame();
    test_tile_extremes();
    test_size_clamps();
    test_ignored_index();
    test_tall_grid();
    test_wide_rows(8192);
    test_wide_rows(16383);
    test_random_frames(0, 0, 50);
    test_random_frames(70, 0, 50);
    test_random_frames(0, 70, 50);
    test_random_frames(13, 13, 50);

    wait_quiet();
    $display("covered %0d height items, %0d vertices, %0d complete frames", items_sent,
             vertices_seen, frames_done);
    $display("grids from clamped minimum to full width, all tile extremes, four idle mixes");
    if (errors == 0) begin
      $display("[heightfield_mesh_vertex_generator] OK");
    end else begin
      $display("[heightfield_mesh_vertex_generator] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/hmvg_pkg.sv
rtl/hmvg_controller.sv
rtl/hmvg_datapath.sv
rtl/heightfield_mesh_vertex_generator.sv
tb/heightfield_mesh_vertex_generator_tb.sv
